>>> sv/rsqs_pkg.sv
`default_nettype none

package rsqs_pkg;

   // ring geometry and id width
   localparam int QUEUE_DEPTH = 32;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int ID_W        = 8;

   // field widths of the channels
   localparam int CMD_W     = 2;
   localparam int PID_W     = 8;
   localparam int PSTATE_W  = 2;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 5;

   localparam logic [ID_W-1:0] IDLE_ID = '1;

   // commands
   localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SWITCH   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_AWAKEN   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_KILL     = 2'd3;

   // process states
   localparam logic [PSTATE_W-1:0] PST_RUNNING  = 2'd0;
   localparam logic [PSTATE_W-1:0] PST_READY    = 2'd1;
   localparam logic [PSTATE_W-1:0] PST_SLEEPING = 2'd2;
   localparam logic [PSTATE_W-1:0] PST_ZOMBIE   = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STS_FULL       = 3'd1;
   localparam logic [STATUS_W-1:0] STS_NOREADY    = 3'd2;
   localparam logic [STATUS_W-1:0] STS_SLEEPEMPTY = 3'd3;
   localparam logic [STATUS_W-1:0] STS_ZOMBIE     = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]    req_type;
      logic [PID_W-1:0]    proc_id;
      logic [PSTATE_W-1:0] proc_state_in;
   } rsqs_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PID_W-1:0]    running_id;
      logic [PSTATE_W-1:0] running_state;
      logic [COUNT_W-1:0]  ready_count;
      logic [COUNT_W-1:0]  sleep_count;
      logic [PID_W-1:0]    next_ready_id;
      logic [PID_W-1:0]    next_sleep_id;
   } rsqs_rsp_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ring_count(input logic [PTR_W-1:0] head,
                                                   input logic [PTR_W-1:0] tail);
      logic [PTR_W:0] d;
      d = {1'b0, tail} - {1'b0, head};
      if (tail < head) begin
         d = d + (PTR_W+1)'(QUEUE_DEPTH);
      end
      return d[PTR_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> sv/ready_sleep_queue_scheduler.sv
// Channel  Ports                          Direction  Beat
// req      req_valid req_ready req_data   in         one command
// rsp      rsp_valid rsp_ready rsp_data   out        status and snapshot
//
// Each command runs accept, execute (ring read data from the head
// read issued the cycle before, ring write, pointer update), report (head
// read of the new pointers lands). The ring RAMs' registered read sets this order.
// Reset is synchronous: pointers zero, running id idle, output empty.
// A report waits while the previous beat is still held on rsp; a new
// command is taken in idle even while a result waits to be taken.
`default_nettype none

module ready_sleep_queue_scheduler (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire rsqs_pkg::rsqs_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsqs_pkg::rsqs_rsp_type      rsp_data
);

   localparam int PTR_W = rsqs_pkg::PTR_W;
   localparam int ID_W  = rsqs_pkg::ID_W;

   typedef enum logic [2:0] {
      FSM_IDLE   = 3'b001,
      FSM_EXEC   = 3'b010,
      FSM_REPORT = 3'b100
   } fsm_type;

   fsm_type fsm_ff, fsm_in;

   rsqs_pkg::rsqs_req_type req_ff;

   logic [PTR_W-1:0] ready_head_ff, ready_head_in, ready_tail_ff, ready_tail_in;
   logic [PTR_W-1:0] sleep_head_ff, sleep_head_in, sleep_tail_ff, sleep_tail_in;
   logic [ID_W-1:0]  cur_id_ff, cur_id_in;
   logic [rsqs_pkg::PSTATE_W-1:0] cur_st_ff, cur_st_in;
   logic [rsqs_pkg::STATUS_W-1:0] sts_ff, sts_in;

   // ring RAMs
   logic [ID_W-1:0] ready_mem [rsqs_pkg::QUEUE_DEPTH];
   logic [ID_W-1:0] sleep_mem [rsqs_pkg::QUEUE_DEPTH];
   logic [ID_W-1:0] ready_rd_ff, sleep_rd_ff;
   logic            ready_push, sleep_push, ready_pop, sleep_pop;
   logic [ID_W-1:0] ready_push_id, sleep_push_id;

   // write/read collision bypass
   logic            ready_fwd_ff, ready_fwd_in, sleep_fwd_ff, sleep_fwd_in;
   logic [ID_W-1:0] ready_fwd_data_ff, sleep_fwd_data_ff;

   logic rsp_valid_ff, rsp_valid_in, rsp_load;
   rsqs_pkg::rsqs_rsp_type rsp_data_ff, rsp_data_in;

   logic ready_empty, ready_full, sleep_empty, sleep_full;
   logic [rsqs_pkg::PSTATE_W-1:0] eff_st;
   logic [PTR_W-1:0] ready_cnt, sleep_cnt;
   logic [ID_W-1:0]  ready_head_id, sleep_head_id;

   assign req_ready = (fsm_ff == FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign ready_empty = (ready_head_ff == ready_tail_ff);
   assign sleep_empty = (sleep_head_ff == sleep_tail_ff);
   assign ready_full  = (rsqs_pkg::ptr_next(ready_tail_ff) == ready_head_ff);
   assign sleep_full  = (rsqs_pkg::ptr_next(sleep_tail_ff) == sleep_head_ff);
   assign eff_st      = (req_ff.req_type == rsqs_pkg::CMD_KILL) ? rsqs_pkg::PST_ZOMBIE
                                                                : cur_st_ff;

   // command execution, only acts in FSM_EXEC
   always_comb begin
      sts_in        = sts_ff;
      cur_id_in     = cur_id_ff;
      cur_st_in     = cur_st_ff;
      ready_push    = 1'b0;
      sleep_push    = 1'b0;
      ready_pop     = 1'b0;
      sleep_pop     = 1'b0;
      ready_push_id = ID_W'(req_ff.proc_id);
      sleep_push_id = ID_W'(req_ff.proc_id);
      if (fsm_ff == FSM_EXEC) begin
         sts_in = rsqs_pkg::STS_OK;
         case (req_ff.req_type)
            rsqs_pkg::CMD_SCHEDULE: begin
               case (req_ff.proc_state_in)
                  rsqs_pkg::PST_READY: begin
                     if (ready_full) sts_in = rsqs_pkg::STS_FULL;
                     else ready_push = 1'b1;
                  end
                  rsqs_pkg::PST_SLEEPING: begin
                     if (sleep_full) sts_in = rsqs_pkg::STS_FULL;
                     else sleep_push = 1'b1;
                  end
                  rsqs_pkg::PST_ZOMBIE: begin
                     sts_in = rsqs_pkg::STS_ZOMBIE;
                  end
                  default: begin
                     sts_in = rsqs_pkg::STS_OK;
                  end
               endcase
            end
            rsqs_pkg::CMD_SWITCH, rsqs_pkg::CMD_KILL: begin
               cur_st_in = eff_st;
               if (ready_empty) begin
                  sts_in = rsqs_pkg::STS_NOREADY;
               end else begin
                  // retire the current process before popping the head
                  if (eff_st == rsqs_pkg::PST_ZOMBIE) begin
                     sts_in = rsqs_pkg::STS_ZOMBIE;
                  end else if (ready_full) begin
                     sts_in = rsqs_pkg::STS_FULL;
                  end else begin
                     ready_push    = 1'b1;
                     ready_push_id = cur_id_ff;
                  end
                  ready_pop = 1'b1;
                  cur_id_in = ready_rd_ff;
                  cur_st_in = rsqs_pkg::PST_RUNNING;
               end
            end
            rsqs_pkg::CMD_AWAKEN: begin
               if (sleep_empty) begin
                  sts_in = rsqs_pkg::STS_SLEEPEMPTY;
               end else begin
                  sleep_pop = 1'b1;
                  if (ready_full) begin
                     sts_in = rsqs_pkg::STS_FULL;
                  end else begin
                     ready_push    = 1'b1;
                     ready_push_id = sleep_rd_ff;
                  end
               end
            end
            default: begin
               sts_in = rsqs_pkg::STS_OK;
            end
         endcase
      end
   end

   assign ready_head_in = ready_pop  ? rsqs_pkg::ptr_next(ready_head_ff) : ready_head_ff;
   assign ready_tail_in = ready_push ? rsqs_pkg::ptr_next(ready_tail_ff) : ready_tail_ff;
   assign sleep_head_in = sleep_pop  ? rsqs_pkg::ptr_next(sleep_head_ff) : sleep_head_ff;
   assign sleep_tail_in = sleep_push ? rsqs_pkg::ptr_next(sleep_tail_ff) : sleep_tail_ff;

   // a push that writes the slot the head read targets (ring empty, or emptied by the pop)
   assign ready_fwd_in = ready_push && (ready_tail_ff == ready_head_in);
   assign sleep_fwd_in = sleep_push && (sleep_tail_ff == sleep_head_in);

   // head reads follow the next pointers, so the head word is registered
   always_ff @(posedge clock) begin
      if (ready_push) begin
         ready_mem[ready_tail_ff] <= ready_push_id;
      end
      ready_rd_ff <= ready_mem[ready_head_in];
   end

   always_ff @(posedge clock) begin
      if (sleep_push) begin
         sleep_mem[sleep_tail_ff] <= sleep_push_id;
      end
      sleep_rd_ff <= sleep_mem[sleep_head_in];
   end

   always_ff @(posedge clock) begin
      ready_fwd_data_ff <= ready_push_id;
      sleep_fwd_data_ff <= sleep_push_id;
      sts_ff            <= sts_in;
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         FSM_IDLE:   if (req_valid) fsm_in = FSM_EXEC;
         FSM_EXEC:   fsm_in = FSM_REPORT;
         FSM_REPORT: if (rsp_load) fsm_in = FSM_IDLE;
         default:    fsm_in = FSM_IDLE;
      endcase
   end

   // report snapshot
   assign ready_cnt     = rsqs_pkg::ring_count(ready_head_ff, ready_tail_ff);
   assign sleep_cnt     = rsqs_pkg::ring_count(sleep_head_ff, sleep_tail_ff);
   assign ready_head_id = ready_fwd_ff ? ready_fwd_data_ff : ready_rd_ff;
   assign sleep_head_id = sleep_fwd_ff ? sleep_fwd_data_ff : sleep_rd_ff;

   always_comb begin
      rsp_data_in.status        = sts_ff;
      rsp_data_in.running_id    = rsqs_pkg::PID_W'(cur_id_ff);
      rsp_data_in.running_state = cur_st_ff;
      rsp_data_in.ready_count   = rsqs_pkg::COUNT_W'(ready_cnt);
      rsp_data_in.sleep_count   = rsqs_pkg::COUNT_W'(sleep_cnt);
      rsp_data_in.next_ready_id = (ready_cnt != '0) ? rsqs_pkg::PID_W'(ready_head_id) : '0;
      rsp_data_in.next_sleep_id = (sleep_cnt != '0) ? rsqs_pkg::PID_W'(sleep_head_id) : '0;
   end

   assign rsp_load     = (fsm_ff == FSM_REPORT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= FSM_IDLE;
         ready_head_ff <= '0;
         ready_tail_ff <= '0;
         sleep_head_ff <= '0;
         sleep_tail_ff <= '0;
         cur_id_ff     <= rsqs_pkg::IDLE_ID;
         cur_st_ff     <= rsqs_pkg::PST_RUNNING;
         ready_fwd_ff  <= 1'b0;
         sleep_fwd_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fsm_ff        <= fsm_in;
         ready_head_ff <= ready_head_in;
         ready_tail_ff <= ready_tail_in;
         sleep_head_ff <= sleep_head_in;
         sleep_tail_ff <= sleep_tail_in;
         cur_id_ff     <= cur_id_in;
         cur_st_ff     <= cur_st_in;
         ready_fwd_ff  <= ready_fwd_in;
         sleep_fwd_ff  <= sleep_fwd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> fsm_ff == FSM_EXEC)
      else $error("accepted beat did not move to execute");

   a_ptr_hold: assert property (@(posedge clock) disable iff (reset)
      fsm_ff != FSM_EXEC |=> $stable(ready_head_ff) && $stable(ready_tail_ff)
                             && $stable(sleep_head_ff) && $stable(sleep_tail_ff))
      else $error("ring pointer moved outside execute");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fsm_ff) == FSM_REPORT)
      else $error("response raised without a report");
`endif

endmodule

`default_nettype wire

>>> tb/sv/rsqs_checker.sv
module rsqs_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire rsqs_pkg::rsqs_req_type req_data,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire rsqs_pkg::rsqs_rsp_type rsp_data,
   output int                          errors,
   output int                          pending,
   output int                          checked,
   output int                          drops,
   output int                          zombies,
   output int                          refusals
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow scheduler state
   logic [rsqs_pkg::ID_W-1:0]     ready_ring [rsqs_pkg::QUEUE_DEPTH];
   logic [rsqs_pkg::ID_W-1:0]     sleep_ring [rsqs_pkg::QUEUE_DEPTH];
   logic [rsqs_pkg::PTR_W-1:0]    ready_hd, ready_tl, sleep_hd, sleep_tl;
   logic [rsqs_pkg::ID_W-1:0]     cur_id;
   logic [rsqs_pkg::PSTATE_W-1:0] cur_st;

   rsqs_pkg::rsqs_rsp_type        snaps_due [$];

   // one slot is kept free, so a ring holds QUEUE_DEPTH-1 ids
   task automatic enqueue(input bit to_sleep, input logic [rsqs_pkg::ID_W-1:0] pid,
                          output logic [rsqs_pkg::STATUS_W-1:0] sts);
      logic [rsqs_pkg::PTR_W-1:0] hd;
      logic [rsqs_pkg::PTR_W-1:0] tl;
      hd = to_sleep ? sleep_hd : ready_hd;
      tl = to_sleep ? sleep_tl : ready_tl;
      if (rsqs_pkg::PTR_W'(tl + 1'b1) == hd) begin
         sts = rsqs_pkg::STS_FULL;
      end else if (to_sleep) begin
         sleep_ring[tl] = pid;
         sleep_tl = rsqs_pkg::PTR_W'(tl + 1'b1);
         sts = rsqs_pkg::STS_OK;
      end else begin
         ready_ring[tl] = pid;
         ready_tl = rsqs_pkg::PTR_W'(tl + 1'b1);
         sts = rsqs_pkg::STS_OK;
      end
   endtask

   // retire the current id (push checked before the head is popped)
   task automatic rotate(output logic [rsqs_pkg::STATUS_W-1:0] sts);
      if (ready_hd == ready_tl) begin
         sts = rsqs_pkg::STS_NOREADY;
      end else begin
         if (cur_st == rsqs_pkg::PST_ZOMBIE) begin
            sts = rsqs_pkg::STS_ZOMBIE;
         end else begin
            enqueue(1'b0, cur_id, sts);
         end
         cur_id = ready_ring[ready_hd];
         ready_hd = rsqs_pkg::PTR_W'(ready_hd + 1'b1);
         cur_st = rsqs_pkg::PST_RUNNING;
      end
   endtask

   task automatic apply_command(input rsqs_pkg::rsqs_req_type c,
                                output rsqs_pkg::rsqs_rsp_type snap);
      logic [rsqs_pkg::STATUS_W-1:0] sts;
      logic [rsqs_pkg::ID_W-1:0]     woken;
      sts = rsqs_pkg::STS_OK;
      case (c.req_type)
         rsqs_pkg::CMD_SCHEDULE: begin
            case (c.proc_state_in)
               rsqs_pkg::PST_READY:    enqueue(1'b0, c.proc_id, sts);
               rsqs_pkg::PST_SLEEPING: enqueue(1'b1, c.proc_id, sts);
               rsqs_pkg::PST_ZOMBIE:   sts = rsqs_pkg::STS_ZOMBIE;
               default:                sts = rsqs_pkg::STS_OK;
            endcase
         end
         rsqs_pkg::CMD_SWITCH: rotate(sts);
         rsqs_pkg::CMD_AWAKEN: begin
            if (sleep_hd == sleep_tl) begin
               sts = rsqs_pkg::STS_SLEEPEMPTY;
            end else begin
               woken = sleep_ring[sleep_hd];
               sleep_hd = rsqs_pkg::PTR_W'(sleep_hd + 1'b1);
               enqueue(1'b0, woken, sts);
            end
         end
         default: begin
            cur_st = rsqs_pkg::PST_ZOMBIE;
            rotate(sts);
         end
      endcase
      snap.status        = sts;
      snap.running_id    = cur_id;
      snap.running_state = cur_st;
      snap.ready_count   = rsqs_pkg::COUNT_W'(rsqs_pkg::PTR_W'(ready_tl - ready_hd));
      snap.sleep_count   = rsqs_pkg::COUNT_W'(rsqs_pkg::PTR_W'(sleep_tl - sleep_hd));
      snap.next_ready_id = (ready_tl != ready_hd) ? ready_ring[ready_hd] : '0;
      snap.next_sleep_id = (sleep_tl != sleep_hd) ? sleep_ring[sleep_hd] : '0;
   endtask

   always @(posedge clock) begin : watch
      rsqs_pkg::rsqs_rsp_type want;
      if (reset) begin
         ready_hd = '0;
         ready_tl = '0;
         sleep_hd = '0;
         sleep_tl = '0;
         cur_id   = rsqs_pkg::IDLE_ID;
         cur_st   = rsqs_pkg::PST_RUNNING;
         snaps_due.delete();
         errors   = 0;
         pending  = 0;
         checked  = 0;
         drops    = 0;
         zombies  = 0;
         refusals = 0;
      end else begin
         if (req_valid && req_ready) begin
            apply_command(req_data, want);
            snaps_due.push_back(want);
            case (want.status)
               rsqs_pkg::STS_FULL:   drops++;
               rsqs_pkg::STS_ZOMBIE: zombies++;
               rsqs_pkg::STS_NOREADY, rsqs_pkg::STS_SLEEPEMPTY: refusals++;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (snaps_due.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("unexpected rsp beat: %p", rsp_data);
               end
            end else begin
               want = snaps_due.pop_front();
               checked++;
               if (want.status !== rsp_data.status ||
                   want.running_id !== rsp_data.running_id ||
                   want.running_state !== rsp_data.running_state ||
                   want.ready_count !== rsp_data.ready_count ||
                   want.sleep_count !== rsp_data.sleep_count ||
                   want.next_ready_id !== rsp_data.next_ready_id ||
                   want.next_sleep_id !== rsp_data.next_sleep_id) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("mismatch on rsp beat %0d (exp/got):", checked);
                     $display("  status %0d/%0d run %h/%h st %0d/%0d",
                              want.status, rsp_data.status,
                              want.running_id, rsp_data.running_id,
                              want.running_state, rsp_data.running_state);
                     $display("  rdy %0d/%0d slp %0d/%0d head %h/%h sleep head %h/%h",
                              want.ready_count, rsp_data.ready_count,
                              want.sleep_count, rsp_data.sleep_count,
                              want.next_ready_id, rsp_data.next_ready_id,
                              want.next_sleep_id, rsp_data.next_sleep_id);
                  end
               end
            end
         end
         pending = snaps_due.size();
      end
   end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_ITEMS     = 1150;
   localparam int LIMIT       = 200000;
   localparam int HOLD_AFTER  = 400;
   localparam int HOLD_CYCLES = 160;

   typedef enum int {SEG_FILL_READY, SEG_FILL_SLEEP, SEG_DRAIN, SEG_MIXED} seg_kind_type;
   typedef enum int {RX_FREE, RX_COIN, RX_SPARSE} rx_mode_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   rsqs_pkg::rsqs_req_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsqs_pkg::rsqs_rsp_type rsp_data;

   int errors, pending, checked, drops, zombies, refusals;
   int sent       = 0;
   int cycles     = 0;
   int burst_left = 1;
   bit offer_up   = 1'b0;

   ready_sleep_queue_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   rsqs_checker chk (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .errors    (errors),
      .pending   (pending),
      .checked   (checked),
      .drops     (drops),
      .zombies   (zombies),
      .refusals  (refusals)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still due", cycles, pending);
         $display("ready_sleep_queue_scheduler test failed");
         $finish;
      end
   end

   function automatic rsqs_pkg::rsqs_req_type command_beat(
      input logic [rsqs_pkg::CMD_W-1:0]    cmd,
      input logic [rsqs_pkg::PID_W-1:0]    pid,
      input logic [rsqs_pkg::PSTATE_W-1:0] pst);
      rsqs_pkg::rsqs_req_type c;
      c.req_type      = cmd;
      c.proc_id       = pid;
      c.proc_state_in = pst;
      return c;
   endfunction

   // fill segments mostly schedule into one ring, to push it toward full; drain segments mostly switch, awaken and kill
   function automatic rsqs_pkg::rsqs_req_type pick_command(input seg_kind_type kind);
      rsqs_pkg::rsqs_req_type c;
      int roll;
      c.req_type      = rsqs_pkg::CMD_W'($urandom);
      c.proc_id       = rsqs_pkg::PID_W'($urandom);
      c.proc_state_in = rsqs_pkg::PSTATE_W'($urandom);
      roll = $urandom_range(0, 99);
      case (kind)
         SEG_FILL_READY: begin
            if (roll < 90) begin
               c.req_type      = rsqs_pkg::CMD_SCHEDULE;
               c.proc_state_in = rsqs_pkg::PST_READY;
            end
         end
         SEG_FILL_SLEEP: begin
            if (roll < 90) begin
               c.req_type      = rsqs_pkg::CMD_SCHEDULE;
               c.proc_state_in = rsqs_pkg::PST_SLEEPING;
            end
         end
         SEG_DRAIN: begin
            if (roll < 40) begin
               c.req_type = rsqs_pkg::CMD_SWITCH;
            end else if (roll < 75) begin
               c.req_type = rsqs_pkg::CMD_AWAKEN;
            end else if (roll < 90) begin
               c.req_type = rsqs_pkg::CMD_KILL;
            end
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic send_beat(input rsqs_pkg::rsqs_req_type c);
      int gap;
      req_valid <= 1'b1;
      req_data  <= c;
      offer_up = 1'b1;
      do @(posedge clock); while (!req_ready);
      sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            offer_up = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // receiver: stall patterns, plus one long hold-off to back the block up
   initial begin : rx
      rx_mode_type mode;
      int left;
      int tick;
      bit held;
      mode = RX_FREE;
      left = 0;
      tick = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sent >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 2));
               left = $urandom_range(8, 60);
            end
            left--;
            tick++;
            case (mode)
               RX_FREE: rsp_ready <= 1'b1;
               RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= (tick % 4 == 0);
            endcase
         end
      end
   end

   initial begin : tx
      seg_kind_type kind;
      int seg_len;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // nothing ready
      send_beat(command_beat(rsqs_pkg::CMD_SWITCH,   8'h3C, rsqs_pkg::PST_SLEEPING));
      // sleep ring empty
      send_beat(command_beat(rsqs_pkg::CMD_AWAKEN,   8'hC3, rsqs_pkg::PST_ZOMBIE));
      // idle id stays, as zombie
      send_beat(command_beat(rsqs_pkg::CMD_KILL,     8'h00, rsqs_pkg::PST_READY));
      // ignored
      send_beat(command_beat(rsqs_pkg::CMD_SCHEDULE, 8'h00, rsqs_pkg::PST_RUNNING));
      // discarded
      send_beat(command_beat(rsqs_pkg::CMD_SCHEDULE, 8'hFF, rsqs_pkg::PST_ZOMBIE));
      send_beat(command_beat(rsqs_pkg::CMD_SCHEDULE, 8'h00, rsqs_pkg::PST_READY));
      send_beat(command_beat(rsqs_pkg::CMD_SCHEDULE, 8'hFF, rsqs_pkg::PST_READY));
      send_beat(command_beat(rsqs_pkg::CMD_SCHEDULE, 8'hA5, rsqs_pkg::PST_SLEEPING));
      send_beat(command_beat(rsqs_pkg::CMD_SCHEDULE, 8'h5A, rsqs_pkg::PST_SLEEPING));
      // zombie retired
      send_beat(command_beat(rsqs_pkg::CMD_SWITCH,   8'hFF, rsqs_pkg::PST_RUNNING));
      send_beat(command_beat(rsqs_pkg::CMD_SWITCH,   8'h81, rsqs_pkg::PST_READY));
      // idle id requeued
      send_beat(command_beat(rsqs_pkg::CMD_SWITCH,   8'h7E, rsqs_pkg::PST_ZOMBIE));
      send_beat(command_beat(rsqs_pkg::CMD_AWAKEN,   8'h00, rsqs_pkg::PST_RUNNING));
      send_beat(command_beat(rsqs_pkg::CMD_KILL,     8'hFF, rsqs_pkg::PST_SLEEPING));
      send_beat(command_beat(rsqs_pkg::CMD_AWAKEN,   8'h0F, rsqs_pkg::PST_READY));
      // sleep ring empty again
      send_beat(command_beat(rsqs_pkg::CMD_AWAKEN,   8'hF0, rsqs_pkg::PST_READY));
      send_beat(command_beat(rsqs_pkg::CMD_KILL,     8'h33, rsqs_pkg::PST_ZOMBIE));
      send_beat(command_beat(rsqs_pkg::CMD_KILL,     8'hCC, rsqs_pkg::PST_RUNNING));
      send_beat(command_beat(rsqs_pkg::CMD_KILL,     8'h55, rsqs_pkg::PST_READY));
      // kill with nothing ready
      send_beat(command_beat(rsqs_pkg::CMD_KILL,     8'hAA, rsqs_pkg::PST_SLEEPING));
      send_beat(command_beat(rsqs_pkg::CMD_SWITCH,   8'h00, rsqs_pkg::PST_RUNNING));

      while (sent < N_ITEMS) begin
         kind = seg_kind_type'($urandom_range(0, 3));
         seg_len = (kind == SEG_FILL_READY || kind == SEG_FILL_SLEEP) ?
                   $urandom_range(32, 45) : $urandom_range(20, 60);
         for (int i = 0; i < seg_len && sent < N_ITEMS; i++) begin
            send_beat(pick_command(kind));
         end
      end
      if (offer_up) begin
         req_valid <= 1'b0;
      end

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("%0d commands sent, %0d rsp beats compared, %0d mismatches",
               sent, checked, errors);
      $display("ring-full drops %0d, zombie discards %0d, empty-ring refusals %0d",
               drops, zombies, refusals);
      if (errors == 0) begin
         $display("ready_sleep_queue_scheduler test passed");
      end else begin
         $display("ready_sleep_queue_scheduler test failed");
      end
      $finish;
   end

endmodule
